@@ rtl/pfla_pkg.sv @@
// Shared constants and codes for the page free list allocator.
`timescale 1ns / 1ps

package pfla_pkg;

    localparam int NUM_PAGES = 256;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int LINK_W    = PAGE_W + 1;
    localparam int COUNT_W   = $clog2(NUM_PAGES + 1);
    localparam int TOTAL_W   = 32;
    localparam int STATUS_W  = 2;

    // Output payload, packed from the lowest bit up.
    localparam int OUT_BITS   = PAGE_W + LINK_W + COUNT_W + 2 * TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W  = ((PAGE_W + 7) / 8) * 8;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_PAGES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd2;

endpackage

@@ rtl/pfla_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module pfla_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/page_free_list_allocator_top.sv @@
// Top level of the page free list allocator: control sequencer around the link RAM.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tuser: opcode; tdata: page_index
//  m_*     | out | m_tvalid / m_tready | tuser: status; tdata: page, link, counters
//  cfg_*   | in  | cfg_we              | cfg_wdata: guard_enable
//
// One request at a time: the request is accepted in S_IDLE and decided in S_START, then the
// link RAM is read. A granted allocate or an unguarded free reads one link, an exhausted pool
// none; a guarded free walks one link per cycle, then reads the link of the freed page.
// Reset needs no clearing pass: a valid bit per link entry stands for the reset chain.
// A finished result waits in the output register; the next request is taken meanwhile
// and only its final cycle waits for that register to empty.
`timescale 1ns / 1ps

module page_free_list_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,  // [0] opcode
    input  logic [pfla_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] page_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfla_pkg::STATUS_W-1:0]   m_tuser,  // [1:0] status
    // [7:0] granted_page, [16:8] prior_link, [25:17] free_pages,
    // [57:26] alloc_total, [89:58] free_total, [95:90] zero
    output logic [pfla_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata
);

    import pfla_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_ALLOC_RD = 3'd3;
    localparam logic [2:0] S_FREE_RD  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                guard_reg;
    logic                op_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [COUNT_W-1:0]  steps_reg, steps_next;
    logic [TOTAL_W-1:0]  alloc_reg, alloc_next;
    logic [TOTAL_W-1:0]  rel_reg, rel_next;
    logic [NUM_PAGES-1:0] valid_reg;
    logic [PAGE_W-1:0]   rd_addr_reg;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic                ram_we, ram_re;
    logic [PAGE_W-1:0]   ram_waddr, ram_raddr;
    logic [LINK_W-1:0]   ram_wdata, ram_rdata;
    logic [LINK_W-1:0]   link_rd;
    logic [LINK_W-1:0]   page_link;

    logic                out_free, fin, fire;
    logic [STATUS_W-1:0] res_status;
    logic [PAGE_W-1:0]   res_granted;
    logic [LINK_W-1:0]   res_prior;

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry that was never written still holds its reset link, its own index plus one.
    assign link_rd   = valid_reg[rd_addr_reg] ? ram_rdata
                                              : {1'b0, rd_addr_reg} + LINK_W'(1);
    assign page_link = {1'b0, page_reg};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fire      = fin && out_free;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fcnt_next   = fcnt_reg;
        steps_next  = steps_reg;
        alloc_next  = alloc_reg;
        rel_next    = rel_reg;
        ram_re      = 1'b0;
        ram_raddr   = head_reg[PAGE_W-1:0];
        ram_we      = 1'b0;
        ram_waddr   = page_reg;
        ram_wdata   = head_reg;
        fin         = 1'b0;
        res_status  = ST_OK;
        res_granted = '0;
        res_prior   = LINK_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (head_reg >= LINK_NONE)
                    begin
                        fin        = 1'b1;
                        res_status = ST_EXHAUSTED;
                        if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_ALLOC_RD;
                    end
                end
                else if (page_link >= LINK_NONE)
                begin
                    fin        = 1'b1;
                    res_status = ST_DOUBLE_FREE;
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (guard_reg && (head_reg < LINK_NONE))
                begin
                    if (head_reg == page_link)
                    begin
                        fin        = 1'b1;
                        res_status = ST_DOUBLE_FREE;
                        if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        steps_next = COUNT_W'(1);
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = page_reg;
                    state_next = S_FREE_RD;
                end
            end
            S_WALK:
            begin
                // The link just read is the next list entry to compare.
                if ((steps_reg == COUNT_W'(NUM_PAGES)) || (link_rd >= LINK_NONE))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = page_reg;
                    state_next = S_FREE_RD;
                end
                else if (link_rd == page_link)
                begin
                    fin        = 1'b1;
                    res_status = ST_DOUBLE_FREE;
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = link_rd[PAGE_W-1:0];
                    steps_next = steps_reg + COUNT_W'(1);
                end
            end
            S_ALLOC_RD:
            begin
                fin         = 1'b1;
                res_granted = head_reg[PAGE_W-1:0];
                if (out_free)
                begin
                    head_next  = link_rd;
                    alloc_next = alloc_reg + TOTAL_W'(1);
                    if (fcnt_reg != '0)
                    begin
                        fcnt_next = fcnt_reg - COUNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_FREE_RD:
            begin
                fin       = 1'b1;
                res_prior = (link_rd >= LINK_NONE) ? LINK_NONE : link_rd;
                if (out_free)
                begin
                    ram_we    = 1'b1;
                    head_next = page_link;
                    rel_next  = rel_reg + TOTAL_W'(1);
                    if (fcnt_reg < COUNT_W'(NUM_PAGES))
                    begin
                        fcnt_next = fcnt_reg + COUNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            guard_reg    <= 1'b1;
            head_reg     <= '0;
            fcnt_reg     <= COUNT_W'(NUM_PAGES);
            steps_reg    <= '0;
            alloc_reg    <= '0;
            rel_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fcnt_reg  <= fcnt_next;
            steps_reg <= steps_next;
            alloc_reg <= alloc_next;
            rel_reg   <= rel_next;
            if (cfg_we)
            begin
                guard_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            page_reg <= s_tdata[PAGE_W-1:0];
        end
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
        if (fire)
        begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= OUT_DATA_W'({rel_next, alloc_next, fcnt_next, res_prior,
                                        res_granted});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= COUNT_W'(NUM_PAGES))
        else $error("free page count above pool size");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (steps_reg <= COUNT_W'(NUM_PAGES)))
        else $error("free list walk ran past the pool size");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_RD) && out_free
        |=> (alloc_reg == $past(alloc_reg) + TOTAL_W'(1)) && m_tvalid
            && (m_tuser == ST_OK))
        else $error("allocate did not advance the allocate total");

    a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) && (op_reg == OP_ALLOC) && (head_reg >= LINK_NONE)
        && out_free
        |=> m_tvalid && (m_tuser == ST_EXHAUSTED) && $stable(head_reg))
        else $error("null head did not report an exhausted pool");

endmodule
